@@ rtl/core/wci_pkg.sv @@
package wci_pkg;

  localparam int CURVE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(CURVE_DEPTH);
  localparam int LEN_W       = 13;
  localparam int SAMPLE_W    = 16;
  localparam int INDEX_W     = 12;
  localparam int FRAC_W      = 16;
  localparam int POS_W       = ADDR_W + FRAC_W;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  localparam logic CMD_SHAPE = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

@@ rtl/core/waveshaper_curve_interpolator_unit.sv @@
// samples pass stage 1, 2, 3 regs then the output register; curve writes give no result
// throughput: one beat per cycle while out_stall allows; writes and samples mix freely
// pipe: position multiply, curve read (two read ports), slope multiply, final add
// reset (rst, synchronous, active high) clears valid bits and the stored length len_reg to zero
// curve memory has no reset; entries read before being written return unknown values
module waveshaper_curve_interpolator_unit import wci_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [LEN_W-1:0]           curve_length,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [INDEX_W-1:0]         entry_index,
  input  logic signed [SAMPLE_W-1:0] entry_value,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] shaped_sample
);

  // configuration register
  logic [LEN_W-1:0] len_reg;

  // stage 1: position product
  logic                v1;
  logic                cmd1;
  logic [POS_W-1:0]    pos1;
  logic [ADDR_W-1:0]   lenm1_1;
  logic                bypass1;
  sample_t             x1;
  logic [INDEX_W-1:0]  widx1;
  sample_t             wval1;

  // stage 2: curve entries read
  logic                v2;
  logic                bypass2;
  sample_t             x2;
  sample_t             c0_2;
  sample_t             c1_2;
  logic [FRAC_W-1:0]   f2;

  // stage 3: rounded slope term
  logic                v3;
  logic                bypass3;
  sample_t             x3;
  sample_t             c0_3;
  logic signed [PROD_W-1:0] prod3;

  // curve memory
  sample_t curve_mem [CURVE_DEPTH];

  // load enables, a stage takes new data when empty or when it moves on
  logic ld_out, ld3, ld2, ld1;

  // stage 0 combinational
  logic [LEN_W-1:0]    len_sat;
  logic [ADDR_W-1:0]   lenm1_0;
  logic [FRAC_W-1:0]   u0;
  logic [POS_W-1:0]    pos0;

  // stage 1 combinational
  logic [ADDR_W-1:0]   k1;
  logic                clamp1;
  logic [ADDR_W-1:0]   addr0;
  logic [ADDR_W-1:0]   addr1;
  logic                wr_en;

  // stage 2 combinational
  logic signed [DIFF_W-1:0] diff2;
  logic signed [PROD_W-1:0] prod2;

  // stage 3 combinational
  logic signed [PROD_W-FRAC_W-1:0] slope3;
  logic signed [PROD_W-FRAC_W-1:0] sum3;

  assign ld_out    = !out_valid || !out_stall;
  assign ld3       = !v3 || ld_out;
  assign ld2       = !v2 || ld3;
  assign ld1       = !v1 || ld2;
  assign in_stall  = !ld1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      len_reg <= curve_length;
    end
  end

  // length above the memory depth saturates; length zero is pass-through
  always_comb begin
    len_sat = (len_reg > LEN_W'(CURVE_DEPTH)) ? LEN_W'(CURVE_DEPTH) : len_reg;
    lenm1_0 = ADDR_W'(len_sat - LEN_W'(1));
    // (x + 1) / 2 as a 0.16 fraction: flip the sign bit
    u0      = {~sample_in[SAMPLE_W-1], sample_in[SAMPLE_W-2:0]};
    pos0    = POS_W'(lenm1_0) * POS_W'(u0);
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      cmd1    <= command;
      pos1    <= pos0;
      lenm1_1 <= lenm1_0;
      bypass1 <= (len_reg == '0);
      x1      <= sample_in;
      widx1   <= entry_index;
      wval1   <= entry_value;
    end
  end

  // integer index and clamp to the last entry; a clamped read takes the last
  // entry on both ports with a zero fraction so the interpolation returns it
  always_comb begin
    k1     = pos1[POS_W-1:FRAC_W];
    clamp1 = (k1 >= lenm1_1);
    addr0  = clamp1 ? lenm1_1 : k1;
    addr1  = clamp1 ? lenm1_1 : k1 + ADDR_W'(1);
    wr_en  = ld2 && v1 && (cmd1 == CMD_WRITE);
  end

  // memory write and both reads sit in the same stage, so program order holds
  always_ff @(posedge clk) begin
    if (wr_en) begin
      curve_mem[widx1[ADDR_W-1:0]] <= wval1;
    end
    if (ld2) begin
      c0_2 <= curve_mem[addr0];
      c1_2 <= curve_mem[addr1];
    end
  end

  // stage 2 register, curve writes end here
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1 && (cmd1 == CMD_SHAPE);
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      bypass2 <= bypass1;
      x2      <= x1;
      f2      <= clamp1 ? '0 : pos1[FRAC_W-1:0];
    end
  end

  // slope times fraction, plus half for round to nearest, ties up
  always_comb begin
    diff2 = DIFF_W'(c1_2) - DIFF_W'(c0_2);
    prod2 = PROD_W'(diff2 * $signed({1'b0, f2}))
          + PROD_W'(1 << (FRAC_W - 1));
  end

  // stage 3 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      bypass3 <= bypass2;
      x3      <= x2;
      c0_3    <= c0_2;
      prod3   <= prod2;
    end
  end

  // floor shift then add the lower entry; result stays inside the two entries
  always_comb begin
    slope3 = prod3[PROD_W-1:FRAC_W];
    sum3   = slope3 + (PROD_W-FRAC_W)'(c0_3);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      shaped_sample <= bypass3 ? x3 : sum3[SAMPLE_W-1:0];
    end
  end

endmodule
